// ===== hdl/cbf_pkg.sv =====
// Package: constants, types and hash helpers for the counting Bloom filter.
`timescale 1ns / 1ps
package cbf_pkg;

  localparam int unsigned NumCounters = 4096;
  localparam int unsigned IdxW        = $clog2(NumCounters);
  localparam int unsigned SizeW       = IdxW + 1;
  localparam int unsigned NumHash     = 8;
  localparam int unsigned HashSelW    = $clog2(NumHash);
  localparam int unsigned ModStepW    = $clog2(33);

  localparam logic [31:0] RsStep   = 32'd378551;
  localparam logic [31:0] RsStart  = 32'd63689;
  localparam logic [31:0] JsStart  = 32'd1315423911;
  localparam logic [31:0] ApStart  = 32'hAAAAAAAA;
  localparam logic [31:0] BkdrSeed = 32'd131;
  localparam logic [31:0] ElfMask  = 32'hF0000000;

  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActDel   = 2'd1,
    ActCheck = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic {
    RegTableSize  = 1'b0,
    RegHashEnable = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  key_byte;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [12:0] index;
    logic [31:0] data;
  } cfg_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic                fold;      // fold the input byte into the hashes
    logic                clear;     // restore hash start values
    logic                mod_start; // start reduction of the selected hash
    logic [HashSelW-1:0] hsel;      // hash being reduced
    logic                rd;        // read counter at reduced index
    logic                wr;        // write modified counter back
    logic [1:0]          action;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic mod_done;
    logic zero;     // counter read was zero
  } sts_t;

endpackage

// ===== hdl/cbf_if.sv =====
// Interface: valid/ready channel with a generic payload.
`timescale 1ns / 1ps
interface cbf_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/cbf_hash.sv =====
// Eight running string hashes, folded one byte a cycle on fold_i.
`timescale 1ns / 1ps
module cbf_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fold_i,
  input  logic                     clear_i,
  input  logic [7:0]               byte_i,
  input  logic [cbf_pkg::HashSelW-1:0] sel_i,
  output logic [31:0]              hash_o
);
  import cbf_pkg::*;

  logic [31:0] h_q [NumHash];
  logic [31:0] h_d [NumHash];
  logic [31:0] rs_mul_q, rs_mul_d;
  logic        par_q, par_d;
  logic [31:0] c, e5, x;

  // Compute the next hash values
  always_comb begin
    c = {{24{byte_i[7]}}, byte_i};
    h_d = h_q;
    rs_mul_d = rs_mul_q;
    par_d = par_q;
    e5 = '0;
    x = '0;
    if (clear_i) begin
      for (int i = 0; i < NumHash; i++) h_d[i] = '0;
      h_d[4] = JsStart;
      h_d[7] = ApStart;
      rs_mul_d = RsStart;
      par_d = 1'b0;
    end else if (fold_i) begin
      h_d[0] = h_q[0] ^ ((h_q[0] << 5) + (h_q[0] >> 2) + c);
      h_d[1] = c + (h_q[1] << 6) + (h_q[1] << 16) - h_q[1];
      h_d[2] = h_q[2] ^ c;
      h_d[2] = h_d[2] + (h_d[2] << 1) + (h_d[2] << 4) + (h_d[2] << 7)
               + (h_d[2] << 8) + (h_d[2] << 24);
      h_d[3] = h_q[3] * rs_mul_q + c;
      rs_mul_d = rs_mul_q * RsStep;
      h_d[4] = h_q[4] ^ ((h_q[4] << 5) + c + (h_q[4] >> 2));
      e5 = (h_q[5] << 4) + c;
      x = e5 & ElfMask;
      h_d[5] = (e5 ^ (x >> 24)) & ~x;
      h_d[6] = h_q[6] * BkdrSeed + c;
      if (!par_q) h_d[7] = h_q[7] ^ ((h_q[7] << 7) ^ (c * (h_q[7] >> 3)));
      else h_d[7] = h_q[7] ^ ~((h_q[7] << 11) + (c ^ (h_q[7] >> 5)));
      par_d = ~par_q;
    end
  end

  // Hold hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumHash; i++) h_q[i] <= '0;
      h_q[4] <= JsStart;
      h_q[7] <= ApStart;
      rs_mul_q <= RsStart;
      par_q <= 1'b0;
    end else begin
      h_q <= h_d;
      rs_mul_q <= rs_mul_d;
      par_q <= par_d;
    end
  end

  assign hash_o = h_q[sel_i];
endmodule

// ===== hdl/cbf_mod.sv =====
// Restoring modulo unit: one quotient bit a cycle over a 32-bit dividend.
`timescale 1ns / 1ps
module cbf_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 dividend_i,
  input  logic [cbf_pkg::SizeW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [cbf_pkg::IdxW-1:0]    rem_o
);
  import cbf_pkg::*;

  logic [31:0]         dvd_q;
  logic [SizeW-1:0]    rem_q;
  logic [SizeW-1:0]    dvs_q;
  logic [ModStepW-1:0] cnt_q;
  logic                busy_q;
  logic [SizeW:0]      trial;

  assign trial = {rem_q, dvd_q[31]} - {1'b0, dvs_q};

  // Shift in one dividend bit and subtract where it fits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ModStepW'(32);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        dvd_q <= dvd_q << 1;
        if (!trial[SizeW]) rem_q <= trial[SizeW-1:0];
        else rem_q <= {rem_q[SizeW-2:0], dvd_q[31]};
        cnt_q <= cnt_q - ModStepW'(1);
        if (cnt_q == ModStepW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign rem_o = rem_q[IdxW-1:0];
endmodule

// ===== hdl/cbf_datapath.sv =====
// Datapath: hashes, modulo unit, counter memory with clearing pass.
`timescale 1ns / 1ps
module cbf_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbf_pkg::cmd_t             cmd_i,
  input  logic [7:0]                byte_i,
  input  logic [cbf_pkg::SizeW-1:0] size_i,
  input  logic                      clr_i,
  input  logic [cbf_pkg::IdxW-1:0]  clr_addr_i,
  output cbf_pkg::sts_t             sts_o
);
  import cbf_pkg::*;

  logic [31:0]     hash;
  logic [IdxW-1:0] rem, idx_q;
  logic            mod_done;
  logic [3:0]      mem [NumCounters];
  logic [3:0]      rd_q, wdata;

  cbf_hash u_hash (
    .clk_i, .rst_ni, .fold_i(cmd_i.fold), .clear_i(cmd_i.clear),
    .byte_i, .sel_i(cmd_i.hsel), .hash_o(hash)
  );

  cbf_mod u_mod (
    .clk_i, .rst_ni, .start_i(cmd_i.mod_start), .dividend_i(hash),
    .divisor_i(size_i), .done_o(mod_done), .rem_o(rem)
  );

  // Latch index when reduction ends
  always_ff @(posedge clk_i) begin
    if (mod_done) idx_q <= rem;
  end

  // Adjust counter by action
  always_comb begin
    unique case (action_e'(cmd_i.action))
      ActAdd:  wdata = rd_q + 4'd1;
      ActDel:  wdata = rd_q - 4'd1;
      default: wdata = rd_q;
    endcase
  end

  // Counter memory: zero the sweep address while clearing, else read then write
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[idx_q];
    if (clr_i) mem[clr_addr_i] <= 4'd0;
    else if (cmd_i.wr) mem[idx_q] <= wdata;
  end

  assign sts_o.mod_done = mod_done;
  assign sts_o.zero     = (rd_q == 4'd0);
endmodule

// ===== hdl/cbf_ctrl.sv =====
// Controller: sequences hashing, reduction, counter update and result.
`timescale 1ns / 1ps
module cbf_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbf_pkg::in_item_t         in_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic                      out_present_o,
  input  logic                      out_ready_i,
  input  logic [7:0]                enable_i,
  output logic                      clr_busy_o,
  output logic [cbf_pkg::IdxW-1:0]  clr_addr_o,
  output cbf_pkg::cmd_t             cmd_o,
  input  cbf_pkg::sts_t             sts_i
);
  import cbf_pkg::*;

  typedef enum logic [2:0] {
    StClear, StIdle, StNext, StMod, StRead, StEval, StDone
  } state_e;

  state_e              state_q;
  logic [HashSelW-1:0] hsel_q;
  logic [1:0]          act_q;
  logic                pres_q;
  logic [IdxW-1:0]     caddr_q;
  logic                mstart_q, rd_q, wr_q;
  logic                acc;

  assign acc        = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle) && !out_valid_o;
  assign clr_busy_o = (state_q == StClear);
  assign clr_addr_o = caddr_q;

  // Drive commands
  always_comb begin
    cmd_o = '0;
    cmd_o.fold      = acc;
    cmd_o.clear     = (state_q == StDone);
    cmd_o.mod_start = mstart_q;
    cmd_o.hsel      = hsel_q;
    cmd_o.rd        = rd_q;
    cmd_o.wr        = wr_q;
    cmd_o.action    = act_q;
  end

  // Sequence one key end over the enabled hashes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      hsel_q      <= '0;
      act_q       <= '0;
      pres_q      <= 1'b1;
      caddr_q     <= '0;
      mstart_q    <= 1'b0;
      rd_q        <= 1'b0;
      wr_q        <= 1'b0;
      out_valid_o <= 1'b0;
      out_present_o <= 1'b0;
    end else begin
      mstart_q <= 1'b0;
      rd_q     <= 1'b0;
      wr_q     <= 1'b0;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        StClear: begin
          caddr_q <= caddr_q + IdxW'(1);
          if (caddr_q == IdxW'(NumCounters - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (acc && in_data_i.last) begin
            act_q  <= in_data_i.action;
            hsel_q <= '0;
            pres_q <= 1'b1;
            if (action_e'(in_data_i.action) == ActNone) state_q <= StDone;
            else state_q <= StNext;
          end
        end
        StNext: begin
          if (enable_i[hsel_q]) begin
            mstart_q <= 1'b1;
            state_q  <= StMod;
          end else if (hsel_q == HashSelW'(NumHash - 1)) begin
            state_q <= StDone;
          end else begin
            hsel_q <= hsel_q + HashSelW'(1);
          end
        end
        StMod: begin
          if (sts_i.mod_done) begin
            rd_q    <= 1'b1;
            state_q <= StRead;
          end
        end
        StRead: state_q <= StEval;
        StEval: begin
          if (action_e'(act_q) == ActCheck) begin
            if (sts_i.zero) pres_q <= 1'b0;
          end else begin
            wr_q <= 1'b1;
          end
          if (hsel_q == HashSelW'(NumHash - 1)) state_q <= StDone;
          else begin
            hsel_q  <= hsel_q + HashSelW'(1);
            state_q <= StNext;
          end
        end
        StDone: begin
          if (action_e'(act_q) != ActNone) begin
            out_valid_o   <= 1'b1;
            out_present_o <= pres_q;
          end
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== hdl/counting_bloom_filter.sv =====
// Top level: counting Bloom filter with 4-bit counters.
//
// Usage: key bytes enter on in_if, one byte per transaction, with the
// action and a last flag; an ordinary byte only feeds the hashes. The
// transaction marked last triggers the action: each enabled hash is
// reduced modulo table_size by a bit-serial divider, then the counter
// is read and, for add or delete, written back; a disabled hash is
// skipped. The enabled hashes take turns on the one shared divider.
// One result transaction (present) follows a key end with action add,
// delete or check; action code three gives none. Configuration writes
// on cfg_if: index 0 table_size, index 1 hash_enable; always accepted.
// After reset a clearing pass zeroes all 4096 counters, during which
// no key byte is accepted. The input is held off while a result waits,
// so a stalled receiver stalls the input.
`timescale 1ns / 1ps
module counting_bloom_filter (
  input  logic clk_i,
  input  logic rst_ni,
  cbf_if.sink   in_if,
  cbf_if.sink   cfg_if,
  cbf_if.source out_if
);
  import cbf_pkg::*;

  logic [12:0]      tsize_q;
  logic [7:0]       hen_q;
  logic [SizeW-1:0] size_eff;
  cmd_t             cmd, cmd_dp;
  sts_t             sts;
  logic             clr_busy, in_ready, out_valid, out_present;
  logic [IdxW-1:0]  clr_addr;
  in_item_t         in_item;
  cfg_item_t        cfg_item;

  assign in_item  = in_if.data;
  assign cfg_item = cfg_if.data;
  assign cfg_if.ready = 1'b1;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tsize_q <= 13'd4096;
      hen_q   <= 8'hFF;
    end else if (cfg_if.valid) begin
      if (cfg_item.index == 13'(RegTableSize)) tsize_q <= cfg_item.data[12:0];
      else if (cfg_item.index == 13'(RegHashEnable)) hen_q <= cfg_item.data[7:0];
    end
  end

  assign size_eff = (tsize_q == '0 || 32'(tsize_q) > NumCounters)
                    ? SizeW'(NumCounters) : SizeW'(tsize_q);

  cbf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_data_i(in_item), .in_valid_i(in_if.valid),
    .in_ready_o(in_ready), .out_valid_o(out_valid), .out_present_o(out_present),
    .out_ready_i(out_if.ready), .enable_i(hen_q), .clr_busy_o(clr_busy),
    .clr_addr_o(clr_addr), .cmd_o(cmd), .sts_i(sts)
  );

  // Clearing pass: force a zero write at the sweep address
  cbf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_dp), .byte_i(in_item.key_byte),
    .size_i(size_eff), .clr_i(clr_busy), .clr_addr_i(clr_addr), .sts_o(sts)
  );

  assign cmd_dp = cmd;
  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;
  assign out_if.data  = out_present;
endmodule

// ===== dv/tb_counting_bloom_filter.sv =====
// Testbench for the counting Bloom filter: directed table, then random keys.
`timescale 1ns / 1ps
module tb_counting_bloom_filter;
  import cbf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cbf_if #(.payload_t(in_item_t))  in_if ();
  cbf_if #(.payload_t(cfg_item_t)) cfg_if ();
  cbf_if #(.payload_t(logic))      out_if ();

  counting_bloom_filter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .cfg_if (cfg_if.sink),
    .out_if (out_if.source)
  );

  // Predictor state
  logic [31:0] hacc [8];
  logic [31:0] rs_mul;
  logic        parity;
  logic [3:0]  counters [NumCounters];
  logic [12:0] tbl_size;
  logic [7:0]  hash_en;

  logic presence_q [$];
  int   n_errors = 0;
  int   n_cycles = 0;
  bit   long_stall = 1'b0;

  // Directed rows: action, byte, last, expected (-1 = use predictor)
  typedef struct {
    action_e    act;
    logic [7:0] kb;
    logic       last;
    int         want;
  } row_t;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic void clear_hashes();
    foreach (hacc[i]) hacc[i] = '0;
    hacc[4] = JsStart;
    hacc[7] = ApStart;
    rs_mul = RsStart;
    parity = 1'b0;
  endfunction

  // Fold a byte; on a key end apply the action and, unless it is none, queue presence
  function automatic void predict_byte(in_item_t it);
    logic [31:0] c, x, sz, idx;
    logic        pres;
    c = {{24{it.key_byte[7]}}, it.key_byte};
    hacc[0] ^= (hacc[0] << 5) + (hacc[0] >> 2) + c;
    hacc[1] = c + (hacc[1] << 6) + (hacc[1] << 16) - hacc[1];
    hacc[2] ^= c;
    hacc[2] += (hacc[2] << 1) + (hacc[2] << 4) + (hacc[2] << 7) + (hacc[2] << 8)
               + (hacc[2] << 24);
    hacc[3] = hacc[3] * rs_mul + c;
    rs_mul = rs_mul * RsStep;
    hacc[4] ^= (hacc[4] << 5) + c + (hacc[4] >> 2);
    hacc[5] = (hacc[5] << 4) + c;
    x = hacc[5] & ElfMask;
    if (x != 0) hacc[5] ^= x >> 24;
    hacc[5] &= ~x;
    hacc[6] = hacc[6] * BkdrSeed + c;
    if (!parity) hacc[7] ^= (hacc[7] << 7) ^ (c * (hacc[7] >> 3));
    else hacc[7] ^= ~((hacc[7] << 11) + (c ^ (hacc[7] >> 5)));
    parity ^= 1'b1;
    if (!it.last) return;
    if (it.action == ActNone) begin
      clear_hashes();
      return;
    end
    sz = (tbl_size == 0 || tbl_size > NumCounters) ? 32'(NumCounters) : 32'(tbl_size);
    pres = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (!hash_en[k]) continue;
      idx = hacc[k] % sz;
      case (it.action)
        ActAdd: counters[idx] = counters[idx] + 4'd1;
        ActDel: counters[idx] = counters[idx] - 4'd1;
        default: if (counters[idx] == 0) pres = 1'b0;
      endcase
    end
    clear_hashes();
    presence_q.push_back(pres);
  endfunction

  // Drive one byte transaction in bursts with random gaps
  task automatic send_byte(in_item_t it);
    if ($urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(it);
  endtask

  // Stop offering bytes
  task automatic idle_in();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [31:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: 13'(r), data: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (r == RegTableSize) tbl_size = v[12:0];
    else hash_en = v[7:0];
    @(posedge clk_i);
  endtask

  // Wait until idle, then let a key end with no result finish
  task automatic drain();
    idle_in();
    while (presence_q.size() != 0) @(posedge clk_i);
    repeat (320) @(posedge clk_i);
  endtask

  task automatic send_key(action_e act, int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.action   = (i == len - 1) ? act : action_e'($urandom_range(0, 3));
      it.key_byte = 8'($urandom_range(1, 255));
      it.last     = (i == len - 1);
      send_byte(it);
    end
  endtask

  // Check results against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (presence_q.size() == 0) report_mismatch("unexpected result", out_if.data, -1);
      else begin
        logic w;
        w = presence_q.pop_front();
        if (out_if.data !== w) report_mismatch("present", out_if.data, w);
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (long_stall) out_if.ready <= 1'b0;
    else if (n_cycles % 512 < 128) out_if.ready <= 1'b1;
    else out_if.ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk_i) begin
    if (n_cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t rows [$];
    in_item_t it;
    int base_len;
    rows = '{
      '{ActCheck, 8'h01, 1'b1, 0}, '{ActAdd, 8'hff, 1'b0, -1}, '{ActAdd, 8'h80, 1'b1, 1},
      '{ActCheck, 8'hff, 1'b0, -1}, '{ActCheck, 8'h80, 1'b1, 1},
      '{ActDel, 8'h7f, 1'b0, -1}, '{ActAdd, 8'hff, 1'b0, -1}, '{ActDel, 8'h80, 1'b1, 1},
      '{ActCheck, 8'h41, 1'b1, -1}, '{ActNone, 8'h55, 1'b0, -1},
      '{ActNone, 8'haa, 1'b1, -1}, '{ActAdd, 8'h00, 1'b1, 1}, '{ActCheck, 8'h00, 1'b1, 1},
      '{ActDel, 8'h00, 1'b1, 1}, '{ActCheck, 8'h00, 1'b1, 0}
    };
    in_if.valid = 1'b0; in_if.data = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    tbl_size = 13'd4096; hash_en = 8'hff;
    foreach (counters[i]) counters[i] = '0;
    clear_hashes();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; fixed expectations override the predictor
    foreach (rows[i]) begin
      it = '{action: rows[i].act, key_byte: rows[i].kb, last: rows[i].last};
      send_byte(it);
      if (rows[i].want >= 0 && presence_q.size() != 0)
        presence_q[$] = logic'(rows[i].want);
    end
    drain();
    write_reg(RegHashEnable, 32'h0);
    send_key(ActAdd, 2); send_key(ActCheck, 3);
    drain();

    // Several settings, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(RegTableSize, 32'd1);    write_reg(RegHashEnable, 32'hff); end
        1: begin write_reg(RegTableSize, 32'd2);    write_reg(RegHashEnable, 32'h81); end
        2: begin write_reg(RegTableSize, 32'd0);    write_reg(RegHashEnable, 32'h5a); end
        3: begin write_reg(RegTableSize, 32'h1fff); write_reg(RegHashEnable, 32'ha5); end
        4: begin write_reg(RegTableSize, 32'd4097); write_reg(RegHashEnable, 32'h01); end
        default: begin
          write_reg(RegTableSize, $urandom_range(3, 64));
          write_reg(RegHashEnable, $urandom_range(0, 255));
        end
      endcase
      base_len = 0;
      while (base_len < 240) begin
        int len, r;
        action_e a;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        r = $urandom_range(0, 19);
        a = (r < 7) ? ActAdd : (r < 10) ? ActDel : (r < 19) ? ActCheck : ActNone;
        send_key(a, len);
        base_len += len;
      end
      if (phase == 3) begin
        // Long receiver hold-off while keys keep coming
        long_stall = 1'b1;
        fork
          begin repeat (2000) @(posedge clk_i); long_stall = 1'b0; end
          begin repeat (6) send_key(ActCheck, 1); idle_in(); end
        join
      end
      drain();
    end

    drain();
    if (n_errors == 0 && presence_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/cbf_pkg.sv
hdl/cbf_if.sv
hdl/cbf_hash.sv
hdl/cbf_mod.sv
hdl/cbf_datapath.sv
hdl/cbf_ctrl.sv
hdl/counting_bloom_filter.sv
dv/tb_counting_bloom_filter.sv
